[rtl/core/chs_pkg.sv]
package chs_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int COORD_W     = 15;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [DEPTH_W-1:0]        depth_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic diff_en;
      logic mul_en;
      logic pop;
      logic push;
      logic emit_clr;
      logic emit_rd;
      logic emit_ld;
   } cmd_type;

   typedef struct packed {
      logic depth_ge2;
      logic cp_pos;
      logic last;
      logic out_free;
      logic emit_last;
   } sts_type;

endpackage

[rtl/core/chs_datapath.sv]
module chs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  chs_pkg::cmd_type    cmd,
   output chs_pkg::sts_type    sts,
   input  chs_pkg::coord_type  req_px,
   input  chs_pkg::coord_type  req_py,
   input  logic                req_first_point,
   input  logic                req_last_point,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output chs_pkg::coord_type  rsp_hull_px,
   output chs_pkg::coord_type  rsp_hull_py,
   output chs_pkg::depth_type  rsp_hull_count,
   output logic                rsp_overflowed,
   output logic                rsp_final_vertex
);
   import chs_pkg::*;

   entry_type stack_ff [STACK_DEPTH];

   coord_type pt_x_ff, pt_y_ff;
   logic      last_ff;
   depth_type depth_ff, depth_in;
   logic      ovf_ff, ovf_in;
   entry_type rd_a_ff, rd_b_ff;
   diff_type  dbx_ff, dby_ff, dcx_ff, dcy_ff;
   prod_type  p1_ff, p2_ff;
   addr_type  k_ff;
   coord_type out_x_ff, out_y_ff;
   depth_type out_count_ff;
   logic      out_ovf_ff, out_final_ff, rsp_valid_ff;

   logic              full;
   depth_type         depth_m1, depth_m2;
   addr_type          addr_a, addr_b;
   logic [PROD_W:0]   cp;
   logic              emit_last;

   assign full     = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign depth_m1 = depth_ff - DEPTH_W'(1);
   assign depth_m2 = depth_ff - DEPTH_W'(2);
   assign addr_a   = cmd.emit_rd ? k_ff : depth_m2[ADDR_W-1:0];
   assign addr_b   = depth_m1[ADDR_W-1:0];
   assign cp       = {p1_ff[PROD_W-1], p1_ff} - {p2_ff[PROD_W-1], p2_ff};
   assign emit_last = (DEPTH_W'(k_ff) == depth_m1);

   always_comb begin
      depth_in = depth_ff;
      ovf_in   = ovf_ff;
      if (cmd.load && req_first_point) begin
         depth_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.pop) begin
         depth_in = depth_m1;
      end else if (cmd.push) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            depth_in = depth_ff + DEPTH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         ovf_ff   <= ovf_in;
         if (cmd.emit_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hull stack memory
   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         stack_ff[depth_ff[ADDR_W-1:0]] <= '{x: pt_x_ff, y: pt_y_ff};
      end
      if (cmd.scan_rd || cmd.emit_rd) begin
         rd_a_ff <= stack_ff[addr_a];
         rd_b_ff <= stack_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_x_ff <= req_px;
         pt_y_ff <= req_py;
         last_ff <= req_last_point;
      end
      if (cmd.diff_en) begin
         dbx_ff <= {rd_b_ff.x[COORD_W-1], rd_b_ff.x} - {rd_a_ff.x[COORD_W-1], rd_a_ff.x};
         dby_ff <= {rd_b_ff.y[COORD_W-1], rd_b_ff.y} - {rd_a_ff.y[COORD_W-1], rd_a_ff.y};
         dcx_ff <= {pt_x_ff[COORD_W-1], pt_x_ff} - {rd_a_ff.x[COORD_W-1], rd_a_ff.x};
         dcy_ff <= {pt_y_ff[COORD_W-1], pt_y_ff} - {rd_a_ff.y[COORD_W-1], rd_a_ff.y};
      end
      if (cmd.mul_en) begin
         p1_ff <= dbx_ff * dcy_ff;
         p2_ff <= dcx_ff * dby_ff;
      end
      if (cmd.emit_clr) begin
         k_ff <= '0;
      end else if (cmd.emit_ld) begin
         k_ff <= k_ff + ADDR_W'(1);
      end
      if (cmd.emit_ld) begin
         out_x_ff     <= rd_a_ff.x;
         out_y_ff     <= rd_a_ff.y;
         out_count_ff <= depth_ff;
         out_ovf_ff   <= ovf_ff;
         out_final_ff <= emit_last;
      end
   end

   assign sts.depth_ge2 = (depth_ff >= DEPTH_W'(2));
   assign sts.cp_pos    = !cp[PROD_W] && (cp != '0);
   assign sts.last      = last_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.emit_last = emit_last;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hull_px      = out_x_ff;
   assign rsp_hull_py      = out_y_ff;
   assign rsp_hull_count   = out_count_ff;
   assign rsp_overflowed   = out_ovf_ff;
   assign rsp_final_vertex = out_final_ff;

endmodule

[rtl/core/chs_control.sv]
module chs_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  chs_pkg::sts_type sts,
   output chs_pkg::cmd_type cmd
);
   import chs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIFF,
      ST_MUL,
      ST_EVAL,
      ST_PUSH,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.depth_ge2) begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_DIFF;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.cp_pos) begin
               state_in = ST_PUSH;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (sts.last) begin
               cmd.emit_clr = 1'b1;
               state_in     = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_ld = 1'b1;
               state_in    = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

[rtl/core/convex_hull_scan_stack_core.sv]
// Graham-scan hull stack for points already sorted by polar angle. Each accepted item
// is latched, then the stack top is tested against it: one test reads the two top
// entries from the stack memory, forms the coordinate differences, the two 16x16
// products and the signed cross product, and pops on a non-left turn. The item is
// pushed once the stack holds fewer than two entries or a test finds a left turn,
// with every point popped at most once. Items marked last then stream the whole hull,
// bottom first, each vertex read from the stack memory and then loaded into the output
// register once the result side has freed it; no new item is accepted until the last
// vertex is in the output register. A push onto a full 64-entry stack is dropped and
// sets the sticky overflow flag until the next first item.
module convex_hull_scan_stack_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  chs_pkg::coord_type req_px,
   input  chs_pkg::coord_type req_py,
   input  logic               req_first_point,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output chs_pkg::coord_type rsp_hull_px,
   output chs_pkg::coord_type rsp_hull_py,
   output chs_pkg::depth_type rsp_hull_count,
   output logic               rsp_overflowed,
   output logic               rsp_final_vertex
);
   import chs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   chs_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   chs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_first_point  (req_first_point),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hull_px      (rsp_hull_px),
      .rsp_hull_py      (rsp_hull_py),
      .rsp_hull_count   (rsp_hull_count),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_final_vertex (rsp_final_vertex)
   );

   // a pop never takes the stack below one entry
   assert property (@(posedge clock) disable iff (reset) cmd.pop |-> sts.depth_ge2)
      else $error("pop with fewer than two entries");

   // emitted hull size always within the stack
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hull_count != '0) && (rsp_hull_count <= DEPTH_W'(STACK_DEPTH)))
      else $error("hull count out of range");

   // no item is taken in the cycle after one is accepted
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while busy");

   // a vertex is loaded only when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.emit_ld)
      else $error("result overwritten before it was taken");

endmodule

[test/tb_convex_hull_scan_stack_core.sv]
`timescale 1ns / 1ps

module tb_convex_hull_scan_stack_core;
   import chs_pkg::*;

   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam int RAND_ITEMS   = 320;
   localparam int DIR_N        = 25;
   localparam int SET_MAX      = 70;

   typedef struct packed {
      coord_type x;
      coord_type y;
      depth_type count;
      logic      ovf;
      logic      fin;
   } vertex_type;

   typedef struct {
      int px;
      int py;
      bit f;
      bit l;
      bit typed;
      int ex;
      int ey;
      int ec;
      bit eo;
   } dir_row_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_px;
   coord_type req_py;
   logic      req_first_point;
   logic      req_last_point;
   logic      rsp_valid;
   logic      rsp_ready;
   coord_type rsp_hull_px;
   coord_type rsp_hull_py;
   depth_type rsp_hull_count;
   logic      rsp_overflowed;
   logic      rsp_final_vertex;

   // hull predictor state
   int  pst_x [STACK_DEPTH];
   int  pst_y [STACK_DEPTH];
   int  pst_depth;
   bit  pst_ovf;

   vertex_type  hull_q [$];
   dir_row_type dir_rows [DIR_N];
   int          set_x [SET_MAX];
   int          set_y [SET_MAX];
   int          set_n;

   bit          calm;
   int          hold_asks;
   int          hold_seen;
   int          hold_left;
   int          rand_sent;
   int          set_no;
   int          errors;
   int          quiet;
   vertex_type  got_v;
   vertex_type  row_v;
   bit          bad;
   int          i;
   int          n;
   int          span;
   int          pick;

   convex_hull_scan_stack_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_first_point  (req_first_point),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hull_px      (rsp_hull_px),
      .rsp_hull_py      (rsp_hull_py),
      .rsp_hull_count   (rsp_hull_count),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_final_vertex (rsp_final_vertex)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint turn_cp(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
      return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
   endfunction

   function automatic int clamp15(int v);
      if (v > 16383) return 16383;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic void predict_hull(int x, int y, bit f, bit l, bit emit);
      longint     cp;
      vertex_type v;
      int         k;
      if (f) begin
         pst_depth = 0;
         pst_ovf   = 1'b0;
      end
      while (pst_depth >= 2) begin
         cp = turn_cp(pst_x[pst_depth-2], pst_y[pst_depth-2],
                      pst_x[pst_depth-1], pst_y[pst_depth-1], x, y);
         if (cp > 0) break;
         pst_depth--;
      end
      if (pst_depth < STACK_DEPTH) begin
         pst_x[pst_depth] = x;
         pst_y[pst_depth] = y;
         pst_depth++;
      end else begin
         pst_ovf = 1'b1;
      end
      if (l && emit) begin
         for (k = 0; k < pst_depth; k++) begin
            v.x     = coord_type'(pst_x[k]);
            v.y     = coord_type'(pst_y[k]);
            v.count = depth_type'(pst_depth);
            v.ovf   = pst_ovf;
            v.fin   = (k == pst_depth - 1);
            hull_q.push_back(v);
         end
      end
   endfunction

   function automatic bit field_ok(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic offer(input coord_type x, input coord_type y, input logic f, input logic l,
                        input bit typed, input vertex_type typed_v);
      req_px          <= x;
      req_py          <= y;
      req_first_point <= f;
      req_last_point  <= l;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_hull(x, y, f, l, !typed);
      if (typed) hull_q.push_back(typed_v);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // points above a random pivot, sorted by polar angle around it
   task automatic build_polar(input int cnt, input int sp);
      int a;
      int b;
      int tx;
      int ty;
      set_n    = cnt;
      set_x[0] = int'($urandom_range(32767)) - 16384;
      set_y[0] = -int'($urandom_range(16384));
      for (a = 1; a < cnt; a++) begin
         set_x[a] = clamp15(set_x[0] + int'($urandom_range(2 * sp)) - sp);
         set_y[a] = clamp15(set_y[0] + 1 + int'($urandom_range(sp - 1)));
      end
      for (a = 2; a < cnt; a++) begin
         tx = set_x[a];
         ty = set_y[a];
         b  = a - 1;
         while (b >= 1 && turn_cp(set_x[0], set_y[0], tx, ty, set_x[b], set_y[b]) > 0) begin
            set_x[b+1] = set_x[b];
            set_y[b+1] = set_y[b];
            b--;
         end
         set_x[b+1] = tx;
         set_y[b+1] = ty;
      end
   endtask

   // strictly convex run, every point stays on the hull
   task automatic build_parabola(input int cnt);
      int a;
      int x0;
      int y0;
      set_n = cnt;
      x0    = int'($urandom_range(32767 - SET_MAX)) - 16384;
      y0    = int'($urandom_range(32767 - 4900)) - 16384;
      for (a = 0; a < cnt; a++) begin
         set_x[a] = x0 + a;
         set_y[a] = y0 + a * a;
      end
   endtask

   task automatic send_set(input bit mark_first, input bit mark_last, input bit squeeze);
      int  a;
      bit  l;
      for (a = 0; a < set_n; a++) begin
         l = mark_last && (a == set_n - 1);
         if (squeeze && l) hold_asks++;
         offer(coord_type'(set_x[a]), coord_type'(set_y[a]), mark_first && (a == 0), l,
               1'b0, '0);
         rand_sent++;
      end
   endtask

   // result side
   initial begin
      rsp_ready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 22);
         end
      end
   end

   // checking and watchdog
   initial begin
      errors = 0;
      quiet  = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (rsp_valid && rsp_ready) begin
            if (hull_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, got x=%0d y=%0d count=%0d",
                        $time, rsp_hull_px, rsp_hull_py, rsp_hull_count);
               errors++;
            end else begin
               got_v = hull_q.pop_front();
               bad   = 1'b0;
               bad |= !field_ok("hull_px", got_v.x, rsp_hull_px);
               bad |= !field_ok("hull_py", got_v.y, rsp_hull_py);
               bad |= !field_ok("hull_count", got_v.count, rsp_hull_count);
               bad |= !field_ok("overflowed", got_v.ovf, rsp_overflowed);
               bad |= !field_ok("final_vertex", got_v.fin, rsp_final_vertex);
               if (bad) errors++;
            end
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("tb_convex_hull_scan_stack_core: done, errors");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_px          <= '0;
      req_py          <= '0;
      req_first_point <= 1'b0;
      req_last_point  <= 1'b0;
      calm      = 1'b0;
      hold_asks = 0;
      rand_sent = 0;
      pst_depth = 0;
      pst_ovf   = 1'b0;
      dir_rows = '{
         '{0, 0, 0, 1, 1, 0, 0, 1, 0},
         '{16383, 16383, 1, 1, 1, 16383, 16383, 1, 0},
         '{-16384, -16384, 1, 1, 1, -16384, -16384, 1, 0},
         '{16383, -16383, 1, 1, 1, 16383, -16383, 1, 0},
         // square
         '{0, 0, 1, 0, 0, 0, 0, 0, 0},
         '{10, 0, 0, 0, 0, 0, 0, 0, 0},
         '{10, 10, 0, 0, 0, 0, 0, 0, 0},
         '{0, 10, 0, 1, 0, 0, 0, 0, 0},
         // collinear middle point pops
         '{0, 0, 1, 0, 0, 0, 0, 0, 0},
         '{5, 0, 0, 0, 0, 0, 0, 0, 0},
         '{10, 0, 0, 1, 0, 0, 0, 0, 0},
         // stack kept after a last point
         '{10, 10, 0, 1, 0, 0, 0, 0, 0},
         // repeated point
         '{3, 3, 1, 0, 0, 0, 0, 0, 0},
         '{3, 3, 0, 1, 0, 0, 0, 0, 0},
         '{3, 3, 0, 1, 0, 0, 0, 0, 0},
         // right turn
         '{0, 0, 1, 0, 0, 0, 0, 0, 0},
         '{10, 0, 0, 0, 0, 0, 0, 0, 0},
         '{5, -5, 0, 1, 0, 0, 0, 0, 0},
         // widest cross products
         '{-16384, -16384, 1, 0, 0, 0, 0, 0, 0},
         '{16383, -16384, 0, 0, 0, 0, 0, 0, 0},
         '{16383, 16383, 0, 0, 0, 0, 0, 0, 0},
         '{-16384, 16383, 0, 1, 0, 0, 0, 0, 0},
         // pop back to a single entry
         '{0, 0, 1, 0, 0, 0, 0, 0, 0},
         '{4, 4, 0, 0, 0, 0, 0, 0, 0},
         '{-4, -4, 0, 1, 0, 0, 0, 0, 0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIR_N; i++) begin
         row_v.x     = coord_type'(dir_rows[i].ex);
         row_v.y     = coord_type'(dir_rows[i].ey);
         row_v.count = depth_type'(dir_rows[i].ec);
         row_v.ovf   = dir_rows[i].eo;
         row_v.fin   = 1'b1;
         offer(coord_type'(dir_rows[i].px), coord_type'(dir_rows[i].py),
               dir_rows[i].f, dir_rows[i].l, dir_rows[i].typed, row_v);
      end

      set_no = 0;
      while (rand_sent < RAND_ITEMS) begin
         calm = (rand_sent >= 120 && rand_sent < 200);
         if (set_no == 14) begin
            req_valid <= 1'b0;
            while (hull_q.size() != 0) @(negedge clock);
         end
         pick = $urandom_range(99);
         if (set_no == 4) begin
            build_parabola(STACK_DEPTH);
            send_set(1'b1, 1'b1, 1'b1);
         end else if (set_no == 9) begin
            build_parabola($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4));
            send_set(1'b1, 1'b1, 1'b0);
         end else if (pick < 85) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(3, 12);
            case ($urandom_range(2))
               0: begin
                  span = 8;
               end
               1: begin
                  span = 300;
               end
               default: begin
                  span = 16384;
               end
            endcase
            build_polar(n, span);
            if (pick < 70) send_set(1'b1, 1'b1, 1'b0);
            else send_set($urandom_range(1), $urandom_range(1), 1'b0);
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               offer(coord_type'($urandom_range(32767)), coord_type'($urandom_range(32767)),
                     $urandom_range(99) < 20, $urandom_range(99) < 25, 1'b0, '0);
               rand_sent++;
            end
         end
         set_no++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (hull_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("tb_convex_hull_scan_stack_core: done, clean");
      end else begin
         $display("tb_convex_hull_scan_stack_core: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/chs_pkg.sv
rtl/core/chs_datapath.sv
rtl/core/chs_control.sv
rtl/core/convex_hull_scan_stack_core.sv
test/tb_convex_hull_scan_stack_core.sv
